/* rtl/gfp_pkg.sv */
// Shared types, constants and the CRC byte update for the gyro frame parser.
package gfp_pkg;

  localparam int DefCountWidth = 32;
  localparam int CntOutWidth   = 32;
  localparam int YawWidth      = 48;
  localparam int RateWidth     = 20;

  localparam logic [7:0]  HDR0     = 8'h0A;
  localparam logic [7:0]  HDR1     = 8'h03;
  localparam logic [7:0]  HDR2     = 8'h04;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [3:0] POS_ANGLE_HI = 4'd3;
  localparam logic [3:0] POS_ANGLE_LO = 4'd4;
  localparam logic [3:0] POS_RATE_HI  = 4'd5;
  localparam logic [3:0] POS_RATE_LO  = 4'd6;
  localparam logic [3:0] POS_CRC_LO   = 4'd7;
  localparam logic [3:0] POS_CRC_HI   = 4'd8;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR1 = 2'd1,
    PH_HDR2 = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  // One input beat held in the input register.
  typedef struct packed {
    logic       valid;
    logic       op;
    logic [7:0] data;
  } beat_t;

  // Frame completion reported by the parser to the integrator.
  typedef struct packed {
    logic        done;
    logic        good;
    logic [15:0] angle;
    logic [15:0] rate_raw;
  } frame_t;

  // Modbus CRC16 update over one byte, reflected polynomial.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    c = crc_in ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/gfp_in_stage.sv */
// Input register stage with stall toward the sender.
module gfp_in_stage
  import gfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  logic       adv,
  output beat_t      beat
);

  logic       accept;
  logic       full;
  logic       held_op;
  logic [7:0] held_data;

  assign in_stall = full && !adv;
  assign accept   = in_valid && !in_stall;
  assign beat     = {full, held_op, held_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (adv) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_op   <= op;
      held_data <= rx_byte;
    end
  end

endmodule

/* rtl/gfp_parser.sv */
// Header hunt, frame byte capture and running CRC check.
module gfp_parser
  import gfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   go,
  input  beat_t  beat,
  output frame_t frame
);

  phase_t      phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic [15:0] crc, crc_next;
  logic [15:0] crc_upd;
  logic [15:0] angle;
  logic [15:0] rate_raw;
  logic [7:0]  crc_lo;
  logic        byte_go;

  assign byte_go = go && (beat.op == OP_BYTE);
  assign crc_upd = crc_byte(crc, beat.data);

  always_comb begin
    phase_next = phase;
    if (byte_go) begin
      unique case (phase)
        PH_HUNT: if (beat.data == HDR0) phase_next = PH_HDR1;
        PH_HDR1: phase_next = (beat.data == HDR1) ? PH_HDR2 : PH_HUNT;
        PH_HDR2: phase_next = (beat.data == HDR2) ? PH_BODY : PH_HUNT;
        PH_BODY: if (pos == POS_CRC_HI) phase_next = PH_HUNT;
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    pos_next = pos;
    crc_next = crc;
    if (byte_go) begin
      unique case (phase)
        PH_HUNT: crc_next = crc_byte(CRC_INIT, beat.data);
        PH_HDR1: crc_next = crc_upd;
        PH_HDR2: begin
          crc_next = crc_upd;
          pos_next = POS_ANGLE_HI;
        end
        PH_BODY: begin
          pos_next = pos + 4'd1;
          // The header bytes are in the checksum too; of the body, only the angle and rate bytes are.
          if (pos <= POS_RATE_LO) crc_next = crc_upd;
        end
        default: pos_next = pos;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= 4'd0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    crc <= crc_next;
    if (byte_go && phase == PH_BODY) begin
      case (pos)
        POS_ANGLE_HI: angle[15:8]    <= beat.data;
        POS_ANGLE_LO: angle[7:0]     <= beat.data;
        POS_RATE_HI:  rate_raw[15:8] <= beat.data;
        POS_RATE_LO:  rate_raw[7:0]  <= beat.data;
        POS_CRC_LO:   crc_lo         <= beat.data;
        default:      crc_lo         <= crc_lo;
      endcase
    end
  end

  always_comb begin
    frame.done     = byte_go && (phase == PH_BODY) && (pos == POS_CRC_HI);
    frame.good     = (crc == {beat.data, crc_lo});
    frame.angle    = angle;
    frame.rate_raw = rate_raw;
  end

endmodule

/* rtl/gfp_integrator.sv */
// Rate correction, saturating yaw accumulator, counters and result register.
module gfp_integrator
  import gfp_pkg::*;
#(
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  beat_t                       beat,
  input  frame_t                      frame,
  input  logic signed [15:0]          rate_bias,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        frame_status,
  output logic signed [15:0]          angle_value,
  output logic signed [RateWidth-1:0] rate_corrected,
  output logic signed [YawWidth-1:0]  yaw_total,
  output logic [CntOutWidth-1:0]      good_frames,
  output logic [CntOutWidth-1:0]      checksum_errors,
  output logic [CntOutWidth-1:0]      bytes_seen
);

  logic signed [YawWidth-1:0]   yaw_accum, yaw_next;
  logic signed [YawWidth:0]     yaw_sum;
  logic signed [RateWidth-1:0]  rate_x10, rate_adj;
  logic [COUNT_WIDTH-1:0]       good_count, error_count, byte_count;
  logic [COUNT_WIDTH-1:0]       byte_count_next;
  logic [COUNT_WIDTH-1:0]       good_out, err_out, bytes_out;
  logic                         byte_go, clear_go, emit;

  localparam logic signed [YawWidth-1:0] YawMax = {1'b0, {(YawWidth-1){1'b1}}};
  localparam logic signed [YawWidth-1:0] YawMin = {1'b1, {(YawWidth-1){1'b0}}};

  assign byte_go  = go && (beat.op == OP_BYTE);
  assign clear_go = go && (beat.op == OP_CLEAR);
  assign emit     = byte_go && frame.done;

  // Raw rate is in 0.1 dps; times ten by shift and add.
  assign rate_x10 = (RateWidth'(signed'(frame.rate_raw)) <<< 3)
                  + (RateWidth'(signed'(frame.rate_raw)) <<< 1);
  assign rate_adj = rate_x10 - RateWidth'(rate_bias);
  assign yaw_sum  = (YawWidth+1)'(yaw_accum) + (YawWidth+1)'(rate_adj);

  always_comb begin
    if (yaw_sum > (YawWidth+1)'(YawMax)) begin
      yaw_next = YawMax;
    end else if (yaw_sum < (YawWidth+1)'(YawMin)) begin
      yaw_next = YawMin;
    end else begin
      yaw_next = yaw_sum[YawWidth-1:0];
    end
  end

  assign byte_count_next = byte_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_accum   <= '0;
      good_count  <= '0;
      error_count <= '0;
      byte_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (clear_go) begin
        yaw_accum <= '0;
      end
      if (byte_go) begin
        byte_count <= byte_count_next;
      end
      if (emit) begin
        if (frame.good) begin
          yaw_accum  <= yaw_next;
          good_count <= good_count + 1'b1;
        end else begin
          error_count <= error_count + 1'b1;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_status <= !frame.good;
      bytes_out    <= byte_count_next;
      if (frame.good) begin
        angle_value    <= frame.angle;
        rate_corrected <= rate_adj;
        yaw_total      <= yaw_next;
        good_out       <= good_count + 1'b1;
        err_out        <= error_count;
      end else begin
        angle_value    <= '0;
        rate_corrected <= '0;
        yaw_total      <= yaw_accum;
        good_out       <= good_count;
        err_out        <= error_count + 1'b1;
      end
    end
  end

  generate
    if (COUNT_WIDTH >= CntOutWidth) begin : g_cnt_trunc
      assign good_frames     = good_out[CntOutWidth-1:0];
      assign checksum_errors = err_out[CntOutWidth-1:0];
      assign bytes_seen      = bytes_out[CntOutWidth-1:0];
    end else begin : g_cnt_ext
      assign good_frames     = CntOutWidth'(good_out);
      assign checksum_errors = CntOutWidth'(err_out);
      assign bytes_seen      = CntOutWidth'(bytes_out);
    end
  endgenerate

endmodule

/* rtl/gyro_frame_parser_yaw_integrator.sv */
// Top level: serial gyro frame parser with CRC check and yaw integrator.
// Takes one beat per clock cycle, with no gaps needed between beats, while the
// result side does not stall. Each beat is a received byte or a yaw-clear command.
// A result beat comes out of the result register once the byte that completes a
// frame (0A 03 04, angle, rate, CRC16 low/high) has passed the input register. A
// stall on the result side holds the input register, so the sender sees at most
// one beat of slack. The running Modbus CRC advances one byte per cycle as beats
// move on, so the check is ready with the last CRC byte. rate_bias is written through
// the cfg port, which is always ready; write it only while no byte is in flight.
module gyro_frame_parser_yaw_integrator
  import gfp_pkg::*;
#(
  parameter int COUNT_WIDTH = DefCountWidth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic signed [15:0]          rate_bias,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        frame_status,
  output logic signed [15:0]          angle_value,
  output logic signed [RateWidth-1:0] rate_corrected,
  output logic signed [YawWidth-1:0]  yaw_total,
  output logic [CntOutWidth-1:0]      good_frames,
  output logic [CntOutWidth-1:0]      checksum_errors,
  output logic [CntOutWidth-1:0]      bytes_seen
);

  beat_t              beat;
  frame_t             frame;
  logic               adv;
  logic signed [15:0] bias;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (cfg_valid && cfg_ready) begin
      bias <= rate_bias;
    end
  end

  // The held beat moves on whenever the result register is free or emptying.
  assign adv = beat.valid && (!out_valid || !out_stall);

  gfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .rx_byte  (rx_byte),
    .adv      (adv),
    .beat     (beat)
  );

  gfp_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .go    (adv),
    .beat  (beat),
    .frame (frame)
  );

  gfp_integrator #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_integ (
    .clk             (clk),
    .rst             (rst),
    .go              (adv),
    .beat            (beat),
    .frame           (frame),
    .rate_bias       (bias),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .frame_status    (frame_status),
    .angle_value     (angle_value),
    .rate_corrected  (rate_corrected),
    .yaw_total       (yaw_total),
    .good_frames     (good_frames),
    .checksum_errors (checksum_errors),
    .bytes_seen      (bytes_seen)
  );

`ifndef ASSERT_OFF
  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> beat.valid)
    else $error("input stalled with an empty input register");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status) |-> (angle_value == '0 && rate_corrected == '0))
    else $error("bad frame carries nonzero angle or rate");

  a_result_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(adv && frame.done))
    else $error("result beat without a completed frame");
`endif

endmodule
